>>> hdl/mets_pkg.sv
// Shared types and constants of the escape-time unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package mets_pkg;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_RE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_IM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 3'd4;

    localparam int ITER_W = 16;
    localparam logic [ITER_W-1:0] MAX_ITER_RESET = 16'd1024;

    // Status of a two-entry queue.
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef enum logic [2:0] {
        MUL_IDLE = 3'b001,
        MUL_ACC  = 3'b010,
        MUL_FIN  = 3'b100
    } t_mul_state;

    typedef enum logic [4:0] {
        BK_IDLE  = 5'b00001,
        BK_MUL   = 5'b00010,
        BK_EVAL1 = 5'b00100,
        BK_EVAL2 = 5'b01000,
        BK_DONE  = 5'b10000
    } t_back_state;

endpackage

`default_nettype wire

>>> hdl/mets_fifo.sv
// Two-entry queue with push/full and pop/empty sides.
// Depends on mets_pkg for the status struct.
`default_nettype none

module mets_fifo #(
    parameter int W = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire logic [W-1:0]        i_data,
    input  wire logic                i_pop,
    output mets_pkg::t_fifo_stat     o_stat,
    output logic      [W-1:0]        o_data
);
    import mets_pkg::*;

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         w_push_ok;
    logic         w_pop_ok;

    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_data       = r_mem[r_rp];
    assign w_push_ok    = i_push && !o_stat.full;
    assign w_pop_ok     = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push_ok) begin
                r_wp <= ~r_wp;
            end
            if (w_pop_ok) begin
                r_rp <= ~r_rp;
            end
            if (w_push_ok && !w_pop_ok) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop_ok && !w_push_ok) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

    ap_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue fill count out of range");

endmodule

`default_nettype wire

>>> hdl/mets_mul.sv
// Multi-cycle signed multiplier: sign-magnitude, 16-bit digits of b per cycle.
// Depends on mets_pkg for its state type.
`default_nettype none

module mets_mul #(
    parameter int DW = 48
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [DW-1:0] i_a,
    input  wire logic signed [DW-1:0] i_b,
    output logic signed [2*DW-1:0]    o_p,
    output logic                      o_done
);
    import mets_pkg::*;

    localparam int CW   = 16;
    localparam int NCH  = (DW + CW - 1) / CW;
    localparam int BW   = NCH * CW;
    localparam int AW   = BW + DW;
    localparam int PW   = 2 * DW;
    localparam int CNTW = $clog2(NCH + 1);

    t_mul_state       r_state;
    logic [DW-1:0]    r_ua;
    logic [BW-1:0]    r_ub;
    logic             r_neg;
    logic [AW-1:0]    r_acc;
    logic [CNTW-1:0]  r_cnt;
    logic [PW-1:0]    r_p;
    logic             r_done;
    logic [DW-1:0]    w_abs_a;
    logic [DW-1:0]    w_abs_b;
    logic [DW+CW-1:0] w_pp;

    assign w_abs_a = i_a[DW-1] ? (~i_a + 1'b1) : i_a;
    assign w_abs_b = i_b[DW-1] ? (~i_b + 1'b1) : i_b;
    // most significant digit first
    assign w_pp    = r_ua * r_ub[BW-1 -: CW];
    assign o_p     = r_p;
    assign o_done  = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MUL_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                MUL_IDLE: begin
                    if (i_start) begin
                        r_ua    <= w_abs_a;
                        r_ub    <= BW'(w_abs_b);
                        r_neg   <= i_a[DW-1] ^ i_b[DW-1];
                        r_acc   <= '0;
                        r_cnt   <= CNTW'(NCH);
                        r_state <= MUL_ACC;
                    end
                end
                MUL_ACC: begin
                    r_acc <= (r_acc << CW) + AW'(w_pp);
                    r_ub  <= r_ub << CW;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNTW'(1)) begin
                        r_state <= MUL_FIN;
                    end
                end
                MUL_FIN: begin
                    r_p     <= r_neg ? (~r_acc[PW-1:0] + 1'b1) : r_acc[PW-1:0];
                    r_done  <= 1'b1;
                    r_state <= MUL_IDLE;
                end
                default: begin
                    r_state <= MUL_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/mets_front.sv
// Front end: takes pixel positions and forms c = origin + position * step.
// Depends on mets_pkg; feeds the coordinate queue.
`default_nettype none

module mets_front #(
    parameter int DW = 48,
    parameter int PB = 12
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire logic [PB-1:0]       i_pixel_x,
    input  wire logic [PB-1:0]       i_pixel_y,
    input  wire logic [DW-1:0]       i_origin_re,
    input  wire logic [DW-1:0]       i_origin_im,
    input  wire logic [DW-2:0]       i_step_re,
    input  wire logic [DW-2:0]       i_step_im,
    input  mets_pkg::t_fifo_stat     i_q_stat,
    output logic                     o_full,
    output logic                     o_q_push,
    output logic [2*DW-1:0]          o_q_data
);
    import mets_pkg::*;

    localparam int PW = PB + DW - 1;
    localparam int SW = PB + DW + 1;

    logic          r_v1;
    logic [PW-1:0] r_prod_re;
    logic [PW-1:0] r_prod_im;
    logic          w_adv;
    logic [SW-1:0] w_sum_re;
    logic [SW-1:0] w_sum_im;

    function automatic logic [DW-1:0] f_sat(input logic [SW-1:0] v);
        if (v[SW-1:DW-1] == '0 || v[SW-1:DW-1] == '1) begin
            return v[DW-1:0];
        end
        return v[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    endfunction

    // the product stage moves when it is empty or the queue takes its item
    assign w_adv    = !r_v1 || !i_q_stat.full;
    assign o_full   = !w_adv;
    assign o_q_push = r_v1 && !i_q_stat.full;
    assign w_sum_re = {2'b00, r_prod_re} + {{(PB+1){i_origin_re[DW-1]}}, i_origin_re};
    assign w_sum_im = {2'b00, r_prod_im} + {{(PB+1){i_origin_im[DW-1]}}, i_origin_im};
    assign o_q_data = {f_sat(w_sum_re), f_sat(w_sum_im)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prod_re <= PW'(i_pixel_x) * PW'(i_step_re);
            r_prod_im <= PW'(i_pixel_y) * PW'(i_step_im);
        end
    end

endmodule

`default_nettype wire

>>> hdl/mets_back.sv
// Back end: iterates z = z*z + c for one coordinate pair at a time.
// Depends on mets_pkg and mets_mul; reads the coordinate queue.
`default_nettype none

module mets_back #(
    parameter int DW = 48,
    parameter int FB = 44
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  mets_pkg::t_fifo_stat      i_q_stat,
    input  wire logic [2*DW-1:0]      i_q_data,
    output logic                      o_q_pop,
    input  wire logic [15:0]          i_max_iter,
    input  wire logic                 i_res_full,
    output logic                      o_res_push,
    output logic [15:0]               o_res_data
);
    import mets_pkg::*;

    localparam int PW = 2 * DW;
    localparam int WW = PW + 1;
    localparam logic signed [WW-1:0] FOUR = {{(WW-1){1'b0}}, 1'b1} << (FB + 2);

    t_back_state              r_state;
    logic signed [DW-1:0]     r_cre;
    logic signed [DW-1:0]     r_cim;
    logic signed [DW-1:0]     r_zx;
    logic signed [DW-1:0]     r_zy;
    logic [ITER_W-1:0]        r_cnt;
    logic [ITER_W-1:0]        r_budget;
    logic [ITER_W-1:0]        r_result;
    logic signed [WW-1:0]     r_diff;
    logic signed [WW-1:0]     r_cross;
    logic                     r_esc;
    logic                     r_start;
    logic signed [PW-1:0]     w_pxx;
    logic signed [PW-1:0]     w_pyy;
    logic signed [PW-1:0]     w_pxy;
    logic                     w_done_xx;
    logic                     w_done_yy;
    logic                     w_done_xy;
    logic signed [PW-1:0]     w_zx2;
    logic signed [PW-1:0]     w_zy2;
    logic signed [PW-1:0]     w_cr;
    logic signed [WW-1:0]     w_zx2_e;
    logic signed [WW-1:0]     w_zy2_e;
    logic signed [WW-1:0]     w_mag;
    logic signed [WW-1:0]     w_nx;
    logic signed [WW-1:0]     w_ny;
    logic [ITER_W-1:0]        w_cnt_inc;

    function automatic logic [DW-1:0] f_sat(input logic [WW-1:0] v);
        if (v[WW-1:DW-1] == '0 || v[WW-1:DW-1] == '1) begin
            return v[DW-1:0];
        end
        return v[WW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    endfunction

    mets_mul #(.DW(DW)) u_mul_xx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_a(r_zx), .i_b(r_zx), .o_p(w_pxx), .o_done(w_done_xx)
    );
    mets_mul #(.DW(DW)) u_mul_yy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_a(r_zy), .i_b(r_zy), .o_p(w_pyy), .o_done(w_done_yy)
    );
    mets_mul #(.DW(DW)) u_mul_xy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_a(r_zx), .i_b(r_zy), .o_p(w_pxy), .o_done(w_done_xy)
    );

    assign w_zx2     = w_pxx >>> FB;
    assign w_zy2     = w_pyy >>> FB;
    // 2*zx*zy: one fraction bit less
    assign w_cr      = w_pxy >>> (FB - 1);
    assign w_zx2_e   = {w_zx2[PW-1], w_zx2};
    assign w_zy2_e   = {w_zy2[PW-1], w_zy2};
    assign w_mag     = w_zx2_e + w_zy2_e;
    assign w_nx      = r_diff + {{(WW-DW){r_cre[DW-1]}}, r_cre};
    assign w_ny      = r_cross + {{(WW-DW){r_cim[DW-1]}}, r_cim};
    assign w_cnt_inc = r_cnt + 1'b1;

    assign o_q_pop    = (r_state == BK_IDLE) && !i_q_stat.empty;
    assign o_res_push = (r_state == BK_DONE) && !i_res_full;
    assign o_res_data = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_start <= 1'b0;
        end else begin
            r_start <= 1'b0;
            case (r_state)
                BK_IDLE: begin
                    if (!i_q_stat.empty) begin
                        r_cre    <= i_q_data[2*DW-1:DW];
                        r_cim    <= i_q_data[DW-1:0];
                        r_zx     <= '0;
                        r_zy     <= '0;
                        r_cnt    <= '0;
                        r_budget <= (i_max_iter == '0) ? ITER_W'(1) : i_max_iter;
                        r_start  <= 1'b1;
                        r_state  <= BK_MUL;
                    end
                end
                BK_MUL: begin
                    if (w_done_xx) begin
                        r_state <= BK_EVAL1;
                    end
                end
                BK_EVAL1: begin
                    r_diff  <= w_zx2_e - w_zy2_e;
                    r_cross <= {w_cr[PW-1], w_cr};
                    // squares of z at zero iterations are zero, so no escape there
                    r_esc   <= (w_mag >= FOUR);
                    r_state <= BK_EVAL2;
                end
                BK_EVAL2: begin
                    if (r_esc) begin
                        r_result <= r_cnt;
                        r_state  <= BK_DONE;
                    end else begin
                        r_zx  <= f_sat(w_nx);
                        r_zy  <= f_sat(w_ny);
                        r_cnt <= w_cnt_inc;
                        if (w_cnt_inc == r_budget) begin
                            // budget used up: inside the set
                            r_result <= '0;
                            r_state  <= BK_DONE;
                        end else begin
                            r_start <= 1'b1;
                            r_state <= BK_MUL;
                        end
                    end
                end
                BK_DONE: begin
                    if (!i_res_full) begin
                        r_state <= BK_IDLE;
                    end
                end
                default: begin
                    r_state <= BK_IDLE;
                end
            endcase
        end
    end

    ap_mul_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done_xx == w_done_yy) && (w_done_xx == w_done_xy))
        else $error("multipliers out of step");

    ap_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done_xx |-> (r_state == BK_MUL))
        else $error("product arrived outside the multiply phase");

    ap_cnt_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_MUL) |-> (r_cnt < r_budget))
        else $error("iteration count passed the budget");

    ap_start_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |=> !r_start)
        else $error("multiply start held for more than one cycle");

endmodule

`default_nettype wire

>>> hdl/mandelbrot_escape_time_unit.sv
// Top level of the escape-time unit: configuration registers, front end,
// coordinate queue, iteration back end and result queue.
// Depends on mets_pkg, mets_fifo, mets_front and mets_back.
// Iteration: NCH = ceil(DATA_WIDTH / 16) digit steps of the multipliers (3 at 48 bits),
//   then BK_EVAL1 and BK_EVAL2; a pixel takes escape_count + 1 iterations, or max_iter.
// Flow: the back end's loop works on one pixel at a time; the front end runs ahead by
//   up to three pixels.
// Reset: synchronous, active low; clears the queues and state machines, loads
//   origin and step with 0 and max_iter with 1024.
`default_nettype none

module mandelbrot_escape_time_unit #(
    parameter int DATA_WIDTH = 48,
    parameter int FRAC_BITS  = 44,
    parameter int PIXEL_BITS = 12
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // pixel side
    input  wire logic                            i_push,
    output logic                                 o_full,
    input  wire logic [PIXEL_BITS-1:0]           i_pixel_x,
    input  wire logic [PIXEL_BITS-1:0]           i_pixel_y,
    // result side
    output logic                                 o_empty,
    input  wire logic                            i_pop,
    output logic [15:0]                          o_escape_count,
    // configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [mets_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [DATA_WIDTH-1:0]           i_cfg_data
);
    import mets_pkg::*;

    localparam int DW = DATA_WIDTH;

    logic [DW-1:0]     r_origin_re;
    logic [DW-1:0]     r_origin_im;
    logic [DW-2:0]     r_step_re;
    logic [DW-2:0]     r_step_im;
    logic [ITER_W-1:0] r_max_iter;

    t_fifo_stat        w_cq_stat;
    logic              w_cq_push;
    logic              w_cq_pop;
    logic [2*DW-1:0]   w_cq_wdata;
    logic [2*DW-1:0]   w_cq_rdata;

    t_fifo_stat        w_rq_stat;
    logic              w_rq_push;
    logic [15:0]       w_rq_wdata;

    // Configuration: always ready; the user must write only while the block is idle
    // (not enforced); the engines read these registers directly. Unknown indexes drop.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_re <= '0;
            r_origin_im <= '0;
            r_step_re   <= '0;
            r_step_im   <= '0;
            r_max_iter  <= MAX_ITER_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ORIGIN_RE: r_origin_re <= i_cfg_data;
                CFG_ORIGIN_IM: r_origin_im <= i_cfg_data;
                CFG_STEP_RE:   r_step_re   <= i_cfg_data[DW-2:0];
                CFG_STEP_IM:   r_step_im   <= i_cfg_data[DW-2:0];
                CFG_MAX_ITER:  r_max_iter  <= i_cfg_data[ITER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: one registered multiply per axis, then add origin and saturate
    // on the way into the coordinate queue.
    mets_front #(
        .DW(DW),
        .PB(PIXEL_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_pixel_x  (i_pixel_x),
        .i_pixel_y  (i_pixel_y),
        .i_origin_re(r_origin_re),
        .i_origin_im(r_origin_im),
        .i_step_re  (r_step_re),
        .i_step_im  (r_step_im),
        .i_q_stat   (w_cq_stat),
        .o_full     (o_full),
        .o_q_push   (w_cq_push),
        .o_q_data   (w_cq_wdata)
    );

    // Coordinate queue: decouples the front end from the long iteration loop.
    mets_fifo #(.W(2 * DW)) u_coord_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_cq_push),
        .i_data (w_cq_wdata),
        .i_pop  (w_cq_pop),
        .o_stat (w_cq_stat),
        .o_data (w_cq_rdata)
    );

    // Back end: three multi-cycle multipliers in lockstep produce zx^2, zy^2 and
    // zx*zy; the states BK_EVAL1 and BK_EVAL2 test escape and form the next z.
    mets_back #(
        .DW(DW),
        .FB(FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_stat  (w_cq_stat),
        .i_q_data  (w_cq_rdata),
        .o_q_pop   (w_cq_pop),
        .i_max_iter(r_max_iter),
        .i_res_full(w_rq_stat.full),
        .o_res_push(w_rq_push),
        .o_res_data(w_rq_wdata)
    );

    // Result queue: hold finished counts while the consumer stalls.
    mets_fifo #(.W(16)) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_rq_push),
        .i_data (w_rq_wdata),
        .i_pop  (i_pop),
        .o_stat (w_rq_stat),
        .o_data (o_escape_count)
    );

    assign o_empty = w_rq_stat.empty;

endmodule

`default_nettype wire

>>> tb/tb_mandelbrot_escape_time_unit.sv
// Self-checking testbench for mandelbrot_escape_time_unit: pixels in, escape counts out.
// Predicts each count in fixed point from a shadow of the configuration registers.
// Depends on mets_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module tb_mandelbrot_escape_time_unit;
    import mets_pkg::*;

    localparam int DW = 48;
    localparam int FB = 44;
    localparam int PB = 12;
    localparam int RESET_CYCLES = 8;
    // Every result has arrived once nothing is pending; allow a short tail anyway.
    localparam int SETTLE_CYCLES = 24;
    localparam int GROUPS_PER_MIX = 6;
    localparam int PIXELS_PER_GROUP = 24;
    localparam int REPORT_LIMIT = 10;
    localparam longint Q_ONE = 64'sd1 <<< FB;

    typedef enum int {FRAME_FULL, FRAME_ZOOM, FRAME_RAW} frame_kind_t;

    typedef struct {
        logic [PB-1:0] x;
        logic [PB-1:0] y;
        logic [15:0]   count;
    } escape_exp_t;

    // Drive every input to a known level from time zero.
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [PB-1:0]     pixel_x = '0;
    logic [PB-1:0]     pixel_y = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic [15:0]       escape_count;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DW-1:0]     cfg_data = '0;

    // Shadow copy of the configuration registers, reset values included.
    logic [DW-1:0]     cfg_origin_re = '0;
    logic [DW-1:0]     cfg_origin_im = '0;
    logic [DW-2:0]     cfg_step_re = '0;
    logic [DW-2:0]     cfg_step_im = '0;
    logic [15:0]       cfg_max_iter = MAX_ITER_RESET;

    escape_exp_t       pending_counts[$];
    int                send_idle_pct = 0;
    int                pop_stall_pct = 0;
    int                hold_request = 0;
    int                hold_left = 0;
    int                pixels_sent = 0;
    int                counts_checked = 0;
    int                count_errors = 0;
    int                frames_loaded = 0;

    always #2 clk = ~clk;

    mandelbrot_escape_time_unit #(
        .DATA_WIDTH(DW),
        .FRAC_BITS (FB),
        .PIXEL_BITS(PB)
    ) uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_pixel_x     (pixel_x),
        .i_pixel_y     (pixel_y),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_escape_count(escape_count),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    // Clamp a wide signed value to the signed DW-bit range.
    function automatic logic signed [DW-1:0] clamp_q(input logic signed [127:0] v);
        logic signed [127:0] q_hi;
        logic signed [127:0] q_lo;
        q_hi = (128'sd1 <<< (DW - 1)) - 128'sd1;
        q_lo = -(128'sd1 <<< (DW - 1));
        if (v > q_hi) return q_hi[DW-1:0];
        if (v < q_lo) return q_lo[DW-1:0];
        return v[DW-1:0];
    endfunction

    // c component = origin + pixel * step, exact product, saturated sum.
    function automatic logic signed [DW-1:0] pixel_coord(input logic [DW-1:0] org,
                                                         input logic [DW-2:0] stp,
                                                         input logic [PB-1:0] pix);
        logic signed [127:0] prod;
        prod = $signed({{(128 - PB){1'b0}}, pix}) * $signed({{(129 - DW){1'b0}}, stp});
        return clamp_q(prod + $signed(org));
    endfunction

    // Iterate z = z*z + c from zero; 0 when the budget runs out, else the pass count.
    function automatic logic [15:0] escape_count_of(input logic [PB-1:0] px,
                                                    input logic [PB-1:0] py);
        logic signed [DW-1:0] cre;
        logic signed [DW-1:0] cim;
        logic signed [DW-1:0] zx;
        logic signed [DW-1:0] zy;
        logic signed [127:0]  wx;
        logic signed [127:0]  wy;
        logic signed [127:0]  sq_x;
        logic signed [127:0]  sq_y;
        logic [16:0]          budget;
        logic [16:0]          passes;
        cre = pixel_coord(cfg_origin_re, cfg_step_re, px);
        cim = pixel_coord(cfg_origin_im, cfg_step_im, py);
        // A zero budget behaves as a budget of one.
        budget = (cfg_max_iter == 16'd0) ? 17'd1 : {1'b0, cfg_max_iter};
        zx = '0;
        zy = '0;
        sq_x = '0;
        sq_y = '0;
        passes = '0;
        while (1'b1) begin
            wx = zx;
            wy = zy;
            zx = clamp_q(sq_x - sq_y + cre);
            zy = clamp_q(((wx * wy) >>> (FB - 1)) + cim);
            wx = zx;
            wy = zy;
            sq_x = (wx * wx) >>> FB;
            sq_y = (wy * wy) >>> FB;
            passes = passes + 17'd1;
            // Budget check wins over escape on the same pass.
            if (passes >= budget) break;
            if (sq_x + sq_y >= (128'sd4 <<< FB)) break;
        end
        return (passes == budget) ? 16'd0 : passes[15:0];
    endfunction

    function automatic logic [PB-1:0] pick_pixel();
        int unsigned roll;
        roll = $urandom_range(15);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return PB'($urandom_range((1 << PB) - 1));
    endfunction

    function automatic logic [15:0] pick_budget();
        int unsigned roll;
        roll = $urandom_range(15);
        if (roll == 0) return 16'd0;
        if (roll < 3) return 16'd1;
        return 16'($urandom_range(2, 48));
    endfunction

    function automatic logic [DW-1:0] rand_word();
        return DW'({$urandom, $urandom});
    endfunction

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        pop_stall_pct = stall_pct;
    endtask

    // Offer one pixel, holding push high until the unit takes the beat.
    task automatic push_pixel(input logic [PB-1:0] x, input logic [PB-1:0] y);
        int gap;
        escape_exp_t item;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        pixel_x <= x;
        pixel_y <= y;
        do @(posedge clk); while (full);
        item.x = x;
        item.y = y;
        item.count = escape_count_of(x, y);
        pending_counts.push_back(item);
        pixels_sent++;
    endtask

    // Drop push and wait for every pending count to come back.
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (pending_counts.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One beat on the configuration channel; the shadow follows the unit's masking.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_ORIGIN_RE: cfg_origin_re = data;
            CFG_ORIGIN_IM: cfg_origin_im = data;
            CFG_STEP_RE:   cfg_step_re = data[DW-2:0];
            CFG_STEP_IM:   cfg_step_im = data[DW-2:0];
            CFG_MAX_ITER:  cfg_max_iter = data[15:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(input logic [DW-1:0] org_re, input logic [DW-1:0] org_im,
                             input logic [DW-1:0] stp_re, input logic [DW-1:0] stp_im,
                             input logic [DW-1:0] budget);
        settle();
        write_reg(CFG_ORIGIN_RE, org_re);
        write_reg(CFG_ORIGIN_IM, org_im);
        write_reg(CFG_STEP_RE, stp_re);
        write_reg(CFG_STEP_IM, stp_im);
        write_reg(CFG_MAX_ITER, budget);
        frames_loaded++;
    endtask

    // Reset values: c = 0 everywhere, so the default budget of 1024 runs out.
    task automatic test_after_reset();
        set_idling(0, 0);
        push_pixel('0, '0);
        push_pixel('1, '1);
    endtask

    // c = -2 lands exactly on |z|^2 = 4, which sits right at the budget edge.
    task automatic test_budget_limits();
        set_frame(DW'(-2 * Q_ONE), '0, '0, '0, 48'd1);
        push_pixel('0, '0);
        settle();
        write_reg(CFG_MAX_ITER, 48'd2);
        push_pixel('0, '0);
        settle();
        write_reg(CFG_MAX_ITER, 48'd0);
        push_pixel('0, '0);
        settle();
        // Bits above the budget field must be dropped.
        write_reg(CFG_MAX_ITER, 48'hFFFF_FFFF_FFFF);
        push_pixel('0, '0);
        // c = -1 cycles forever; c = 0.5 escapes after a few passes.
        set_frame(DW'(-Q_ONE), '0, DW'(Q_ONE >>> 4), '0, 48'd20);
        push_pixel('0, '0);
        push_pixel(PB'(24), '0);
    endtask

    // Drive c to both ends of the range, saturating at the top; the step write carries a stray top bit.
    task automatic test_coord_saturation();
        set_frame(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'hFFFF_FFFF_FFFF,
                  48'hFFFF_FFFF_FFFF, 48'd65535);
        push_pixel('0, '0);
        push_pixel('1, '1);
        push_pixel('1, '0);
        push_pixel('0, '1);
        set_frame(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, '0, '0, 48'd65535);
        push_pixel('0, '0);
    endtask

    // Writes past the last register must leave every register alone.
    task automatic test_unused_index();
        logic [CFG_IDX_W-1:0] idx;
        set_frame(DW'(-2 * Q_ONE), '0, '0, '0, 48'd3);
        idx = CFG_MAX_ITER;
        while (idx != '1) begin
            idx = idx + 1'b1;
            write_reg(idx, DW'(Q_ONE));
        end
        push_pixel(PB'(1), PB'(1));
    endtask

    // Hold off the result side so the unit fills and stalls its input.
    task automatic test_backpressure();
        set_frame(DW'(-9 * (Q_ONE >>> 2)), DW'(-3 * (Q_ONE >>> 1)),
                  DW'(3 * (Q_ONE >>> PB)), DW'(3 * (Q_ONE >>> PB)), 48'd2);
        set_idling(0, 0);
        hold_request = 500;
        repeat (12) push_pixel(pick_pixel(), pick_pixel());
        settle();
    endtask

    // Random frames and budgets under one idling mix.
    task automatic test_random_frames(input int send_pct, input int stall_pct);
        frame_kind_t kind;
        longint org_re;
        longint org_im;
        longint stp_re;
        longint stp_im;
        set_idling(send_pct, stall_pct);
        for (int g = 0; g < GROUPS_PER_MIX; g++) begin
            kind = frame_kind_t'($urandom_range(2));
            case (kind)
                FRAME_FULL: begin
                    org_re = -9 * (Q_ONE >>> 2);
                    org_im = -3 * (Q_ONE >>> 1);
                    stp_re = 3 * (Q_ONE >>> PB);
                    stp_im = stp_re;
                end
                FRAME_ZOOM: begin
                    org_re = -2 * Q_ONE + longint'($urandom_range(2559)) * (Q_ONE >>> 10);
                    org_im = -(5 * (Q_ONE >>> 2))
                             + longint'($urandom_range(2559)) * (Q_ONE >>> 10);
                    stp_re = longint'($urandom_range(1, 3 << 20)) <<< 12;
                    stp_im = longint'($urandom_range(1, 3 << 20)) <<< 12;
                end
                default: begin
                    org_re = longint'(rand_word());
                    org_im = longint'(rand_word());
                    stp_re = longint'(rand_word());
                    stp_im = longint'(rand_word());
                end
            endcase
            set_frame(DW'(org_re), DW'(org_im), DW'(stp_re), DW'(stp_im),
                      DW'(pick_budget()));
            repeat (PIXELS_PER_GROUP) push_pixel(pick_pixel(), pick_pixel());
        end
    endtask

    // Result side: check each popped beat, then decide the next pop.
    always @(posedge clk) begin
        escape_exp_t want;
        if (pop && !empty) begin
            counts_checked++;
            if (pending_counts.size() == 0) begin
                count_errors++;
                if (count_errors <= REPORT_LIMIT)
                    $display("unexpected escape count %0d with nothing pending", escape_count);
            end else begin
                want = pending_counts.pop_front();
                if (escape_count !== want.count) begin
                    count_errors++;
                    if (count_errors <= REPORT_LIMIT)
                        $display("escape count mismatch at pixel (%0d,%0d): expected %0d, got %0d",
                                 want.x, want.y, want.count, escape_count);
                end
            end
        end
        // Count down a requested hold-off here, in the receiver's own process.
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_budget_limits();
        test_coord_saturation();
        test_unused_index();
        test_backpressure();
        test_random_frames(0, 0);
        test_random_frames(61, 0);
        test_random_frames(0, 61);
        test_random_frames(22, 22);
        settle();
        $display("Checked %0d escape counts from %0d pixels over %0d frame loads.",
                 counts_checked, pixels_sent, frames_loaded);
        $display("Budgets from 0 to 65535, saturated coordinates, and a held-off result side.");
        if (count_errors == 0 && pending_counts.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d counts still pending", count_errors,
                     pending_counts.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Stop a hung run well past the slowest legal completion.
    initial begin
        #10_000_000;
        $display("run timed out with %0d counts pending", pending_counts.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
